>>> rtl/key_value_ipv4_parser_defines.svh
// assertion macros used by the checker file
`ifndef KEY_VALUE_IPV4_PARSER_DEFINES_SVH
`define KEY_VALUE_IPV4_PARSER_DEFINES_SVH

// same-cycle implication, held off while reset is asserted
`define KVIP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kvip check failed");

// next-cycle implication, held off while reset is asserted
`define KVIP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kvip check failed");

`endif

>>> rtl/kvip_pkg.sv
package kvip_pkg;

  // default longest key name in bytes
  localparam int unsigned KEY_MAX_DEF = 8;

  // register file shape
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 64;

  // register select, address bit 3
  localparam logic REG_KEY_CHARS  = 1'b0;
  localparam logic REG_KEY_LENGTH = 1'b1;

  // characters the parser reacts to
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_EQ   = 8'h3D;

  localparam logic [1:0] MAX_DIGITS = 2'd3;
  localparam logic [1:0] LAST_OCTET = 2'd3;

  typedef enum logic [1:0] {
    PH_KEY,
    PH_ADDR,
    PH_DONE
  } kvip_phase_e;

  // parser state apart from the key position
  typedef struct packed {
    kvip_phase_e phase;
    logic [1:0]  octet_idx;
    logic [1:0]  digit_cnt;
    logic [9:0]  octet_val;
    logic [23:0] assembled;
  } kvip_state_t;

  localparam kvip_state_t ST_RESET = '{
    phase:     PH_KEY,
    octet_idx: 2'd0,
    digit_cnt: 2'd0,
    octet_val: 10'd0,
    assembled: 24'd0
  };

  // one result of the parse step
  typedef struct packed {
    logic        valid;
    logic        matched;
    logic [31:0] address;
  } kvip_res_t;

endpackage

>>> rtl/kvip_in_if.sv
interface kvip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

>>> rtl/kvip_out_if.sv
interface kvip_out_if;
  logic        valid;
  logic        ready;
  logic        matched;
  logic [31:0] address;

  modport source (output valid, output matched, output address, input ready);
  modport sink   (input valid, input matched, input address, output ready);
endinterface

>>> rtl/kvip_cfg.sv
module kvip_cfg
  import kvip_pkg::*;
#(
  parameter int unsigned KEY_MAX = KEY_MAX_DEF,
  localparam int unsigned KPOS_W = $clog2(KEY_MAX + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [63:0]           key_chars_o,
  output logic [KPOS_W-1:0]     key_len_o
);

  logic [63:0] key_chars_q, key_chars_d;
  logic [3:0]  key_len_q, key_len_d;
  logic        reg_sel;
  logic        wr_en;

  assign reg_sel = paddr[3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register write decode
  always_comb begin
    key_chars_d = key_chars_q;
    key_len_d   = key_len_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_KEY_CHARS:  key_chars_d = pwdata[63:0];
        REG_KEY_LENGTH: key_len_d   = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_chars_q <= '0;
      key_len_q   <= '0;
    end else begin
      key_chars_q <= key_chars_d;
      key_len_q   <= key_len_d;
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      REG_KEY_CHARS:  prdata = APB_DATA_W'(key_chars_q);
      REG_KEY_LENGTH: prdata = APB_DATA_W'(key_len_q);
      default:        prdata = '0;
    endcase
  end

  // lengths beyond the key store count as the full store
  assign key_chars_o = key_chars_q;
  assign key_len_o   = (key_len_q > KEY_MAX) ? KPOS_W'(KEY_MAX) : KPOS_W'(key_len_q);

endmodule

>>> rtl/kvip_step.sv
module kvip_step
  import kvip_pkg::*;
#(
  parameter int unsigned KEY_MAX = KEY_MAX_DEF,
  localparam int unsigned KPOS_W = $clog2(KEY_MAX + 1)
) (
  input  kvip_state_t       st_i,
  input  logic [KPOS_W-1:0] kpos_i,
  input  logic [7:0]        byte_i,
  input  logic [63:0]       key_chars_i,
  input  logic [KPOS_W-1:0] key_len_i,
  output kvip_state_t       st_o,
  output logic [KPOS_W-1:0] kpos_o,
  output kvip_res_t         res_o
);

  logic [7:0] key_byte;
  logic       is_digit;
  logic       digit_ok;
  logic [3:0] digit;
  logic [9:0] val_next;
  logic       decide;
  logic       pass;

  // key byte at the current match position
  always_comb begin
    key_byte = '0;
    for (int i = 0; i < KEY_MAX; i++) begin
      if (kpos_i == KPOS_W'(i)) key_byte = key_chars_i[8*i +: 8];
    end
  end

  // decimal digit accumulation, kept to 10 bits
  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign digit_ok = is_digit && (st_i.digit_cnt != MAX_DIGITS);
  assign digit    = 4'(byte_i - CH_ZERO);
  assign val_next = (st_i.octet_val << 3) + (st_i.octet_val << 1) + {6'd0, digit};

  // next state and result
  always_comb begin
    st_o   = st_i;
    kpos_o = kpos_i;
    res_o  = '0;
    decide = 1'b0;
    pass   = 1'b0;
    unique case (st_i.phase)
      PH_DONE: begin
        if (byte_i == CH_NUL) begin
          st_o   = ST_RESET;
          kpos_o = '0;
        end
      end
      PH_KEY: begin
        if (kpos_i < key_len_i) begin
          if (byte_i == CH_NUL || byte_i != key_byte) begin
            decide = 1'b1;
          end else begin
            kpos_o = kpos_i + KPOS_W'(1);
          end
        end else if (byte_i != CH_EQ) begin
          decide = 1'b1;
        end else begin
          st_o       = ST_RESET;
          st_o.phase = PH_ADDR;
        end
      end
      PH_ADDR: begin
        if (st_i.octet_idx != LAST_OCTET) begin
          if (byte_i == CH_DOT) begin
            case (st_i.octet_idx)
              2'd0:    st_o.assembled[7:0]   = st_i.octet_val[7:0];
              2'd1:    st_o.assembled[15:8]  = st_i.octet_val[7:0];
              default: st_o.assembled[23:16] = st_i.octet_val[7:0];
            endcase
            st_o.octet_idx = st_i.octet_idx + 2'd1;
            st_o.digit_cnt = '0;
            st_o.octet_val = '0;
          end else if (byte_i == CH_NUL || byte_i == CH_LF || !digit_ok) begin
            decide = 1'b1;
          end else begin
            st_o.digit_cnt = st_i.digit_cnt + 2'd1;
            st_o.octet_val = val_next;
          end
        end else if (byte_i == CH_SP || byte_i == CH_NUL || byte_i == CH_LF) begin
          decide = 1'b1;
          pass   = 1'b1;
        end else if (!digit_ok) begin
          decide = 1'b1;
        end else begin
          st_o.digit_cnt = st_i.digit_cnt + 2'd1;
          st_o.octet_val = val_next;
        end
      end
      default: begin
        st_o   = ST_RESET;
        kpos_o = '0;
      end
    endcase

    // a decision rearms, and waits for a nul unless it was one
    if (decide) begin
      res_o.valid   = 1'b1;
      res_o.matched = pass;
      res_o.address = pass ? {st_i.octet_val[7:0], st_i.assembled} : 32'd0;
      st_o          = ST_RESET;
      kpos_o        = '0;
      if (byte_i != CH_NUL) st_o.phase = PH_DONE;
    end
  end

endmodule

>>> rtl/key_value_ipv4_parser.sv
// Key-value IPv4 parser: takes one text byte per transaction on text_i, matches
// the key held in key_chars/key_length, then '=' and a dotted-decimal address,
// and gives one pass or fail transaction on result_o per record. A byte is taken
// every cycle while result_o is not stalled; it passes an input register, the
// combinational parse step and a result register on the way to result_o. The
// parse step, with its multiply by ten of the current octet, sets the rate of one
// byte per cycle while result_o is not stalled.
module key_value_ipv4_parser
  import kvip_pkg::*;
#(
  parameter int unsigned KEY_MAX = KEY_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  kvip_in_if.sink               text_i,
  kvip_out_if.source            result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned KPOS_W = $clog2(KEY_MAX + 1);

  logic [63:0]       key_chars;
  logic [KPOS_W-1:0] key_len;

  logic              in_vld_q, in_vld_d;
  logic [7:0]        byte_q;
  kvip_state_t       st_q, st_d, st_nxt;
  logic [KPOS_W-1:0] kpos_q, kpos_d, kpos_nxt;
  kvip_res_t         res_nxt;
  logic              res_vld_q, res_vld_d;
  logic              matched_q;
  logic [31:0]       addr_q;
  logic              advance;
  logic              step_en;

  kvip_cfg #(
    .KEY_MAX (KEY_MAX)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .key_chars_o (key_chars),
    .key_len_o   (key_len)
  );

  kvip_step #(
    .KEY_MAX (KEY_MAX)
  ) u_step (
    .st_i        (st_q),
    .kpos_i      (kpos_q),
    .byte_i      (byte_q),
    .key_chars_i (key_chars),
    .key_len_i   (key_len),
    .st_o        (st_nxt),
    .kpos_o      (kpos_nxt),
    .res_o       (res_nxt)
  );

  // the held byte moves on whenever the result register is free
  assign advance      = !res_vld_q || result_o.ready;
  assign step_en      = in_vld_q && advance;
  assign text_i.ready = !in_vld_q || advance;

  always_comb begin
    in_vld_d  = text_i.ready ? text_i.valid : in_vld_q;
    st_d      = step_en ? st_nxt : st_q;
    kpos_d    = step_en ? kpos_nxt : kpos_q;
    res_vld_d = advance ? (step_en && res_nxt.valid) : res_vld_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      st_q      <= ST_RESET;
      kpos_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      st_q      <= st_d;
      kpos_q    <= kpos_d;
      res_vld_q <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (text_i.ready && text_i.valid) byte_q <= text_i.text_byte;
    if (step_en && res_nxt.valid) begin
      matched_q <= res_nxt.matched;
      addr_q    <= res_nxt.address;
    end
  end

  assign result_o.valid   = res_vld_q;
  assign result_o.matched = matched_q;
  assign result_o.address = addr_q;

endmodule

>>> rtl/kvip_checker.sv
`include "key_value_ipv4_parser_defines.svh"

module kvip_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        matched,
  input logic [31:0] address
);

  // a failed record never carries an address
  `KVIP_ASSERT_IMP(a_fail_zero_addr, clk_i, rst_ni, out_valid && !matched, address == 32'd0)

  // input side keeps flowing whenever the result side is not stalled
  `KVIP_ASSERT_IMP(a_ready_when_free, clk_i, rst_ni, !(out_valid && !out_ready), in_ready)

  // a stalled result stays in place
  `KVIP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready,
                   out_valid && $stable(matched) && $stable(address))

  // a new result only follows an input transaction held in the input register
  `KVIP_ASSERT_NXT(a_no_idle_result, clk_i, rst_ni,
                   !out_valid && !(in_valid && in_ready) && !$past(in_valid && in_ready),
                   !out_valid)

endmodule

bind key_value_ipv4_parser kvip_checker u_kvip_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (text_i.valid),
  .in_ready  (text_i.ready),
  .out_valid (result_o.valid),
  .out_ready (result_o.ready),
  .matched   (result_o.matched),
  .address   (result_o.address)
);
